// ----- rtl/core/json_token_scanner_defines.svh -----
// Assertion macros shared by the scanner's checker.
`ifndef JSON_TOKEN_SCANNER_DEFINES_SVH
`define JSON_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define JTS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("jts assertion failed");

// next-cycle implication
`define JTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("jts assertion failed");

`endif

// ----- rtl/core/jts_pkg.sv -----
// Shared types and constants of the JSON token scanner.
`default_nettype none
package jts_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int OUT_BITS          = 32;
	localparam int FIFO_DEPTH        = 4;

	typedef enum logic [3:0] {
		K_NULL, K_BOOL, K_STRING, K_INT, K_DOUBLE, K_ARR_S, K_ARR_E,
		K_OBJ_S, K_OBJ_E, K_COLON, K_COMMA, K_END, K_UNKNOWN
	} kind_t;

	typedef enum logic [3:0] {
		E_NONE, E_UNKNOWN_BYTE, E_INCOMPLETE_LIT, E_WRONG_LIT, E_UNTERM_STR,
		E_BAD_ESCAPE, E_BAD_INT, E_BAD_FRAC, E_BAD_EXP
	} err_t;

	typedef enum logic [3:0] {
		M_IDLE, M_LIT, M_STR, M_ESC, M_HEX, M_NSIGN, M_NZERO, M_NINT,
		M_NZBAD, M_FDOT, M_FRAC, M_EXPE, M_EXPS, M_EXP
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       is_end;
		logic       doc_start;
	} item_t;

	typedef struct packed {
		kind_t                kind;
		logic [OUT_BITS-1:0]  start;
		logic [OUT_BITS-1:0]  len;
		err_t                 err;
		logic                 last;
	} event_t;

endpackage
`default_nettype wire

// ----- rtl/core/jts_scan_core.sv -----
// Scanner state registers and the per-byte mode transition logic.
`default_nettype none
module jts_scan_core #(
	parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire jts_pkg::item_t   item,
	output jts_pkg::event_t       ev0,
	output jts_pkg::event_t       ev1,
	output logic [1:0]            ev_cnt
);

	localparam int P = POSITION_BITS;
	localparam int W = (P > jts_pkg::OUT_BITS) ? P : jts_pkg::OUT_BITS;
	localparam logic [P-1:0] PosMax = '1;

	typedef struct packed {
		jts_pkg::kind_t kind;
		logic [P-1:0]   start;
		logic [P-1:0]   len;
		jts_pkg::err_t  err;
	} raw_ev_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F"));
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return (b == " ") || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	// literal spellings: 0 null, 1 true, 2 false
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] i);
		logic [7:0] c;
		c = "n";
		unique case ({w, i})
			5'b00_000: c = "n";
			5'b00_001: c = "u";
			5'b00_010: c = "l";
			5'b00_011: c = "l";
			5'b01_000: c = "t";
			5'b01_001: c = "r";
			5'b01_010: c = "u";
			5'b01_011: c = "e";
			5'b10_000: c = "f";
			5'b10_001: c = "a";
			5'b10_010: c = "l";
			5'b10_011: c = "s";
			5'b10_100: c = "e";
			default:   c = "n";
		endcase
		return c;
	endfunction

	function automatic logic [jts_pkg::OUT_BITS-1:0] clamp_out(input logic [P-1:0] v);
		logic [W-1:0] x;
		x = W'(v);
		return ((x >> jts_pkg::OUT_BITS) != '0) ? '1 : x[jts_pkg::OUT_BITS-1:0];
	endfunction

	function automatic raw_ev_t mk_ev(input jts_pkg::kind_t k, input logic [P-1:0] s,
			input logic [P-1:0] l, input jts_pkg::err_t e);
		raw_ev_t r;
		r.kind  = k;
		r.start = s;
		r.len   = l;
		r.err   = e;
		return r;
	endfunction

	jts_pkg::mode_t mode_q, cur_mode, n_mode;
	logic [1:0]     which_q, cur_which, n_which;
	logic [2:0]     index_q, cur_index, n_index;
	logic [2:0]     hex_q, cur_hex, n_hex;
	logic           frac_q, cur_frac, n_frac;
	logic [P-1:0]   pos_q, cur_pos, n_pos;
	logic [P-1:0]   tstart_q, cur_tstart, n_tstart;
	logic           halted_q, cur_halted, n_halted;

	logic [7:0]     b;
	logic [P-1:0]   next_pos, len_pos, len_next;
	raw_ev_t        r0, r1;
	logic [1:0]     cnt;
	logic           use_idle;

	// idle decode of the current byte
	logic           idle_space, idle_emit, idle_fail, idle_lit;
	jts_pkg::mode_t idle_mode;
	jts_pkg::kind_t idle_kind;
	logic [1:0]     idle_which;

	// literal lookup
	logic [1:0]     lw;
	logic [2:0]     llen, li, li_inc;

	assign b = item.in_byte;

	// doc_start clears everything before the item is scanned
	always_comb begin
		if (item.doc_start) begin
			cur_mode   = jts_pkg::M_IDLE;
			cur_which  = '0;
			cur_index  = '0;
			cur_hex    = '0;
			cur_frac   = 1'b0;
			cur_pos    = '0;
			cur_tstart = '0;
			cur_halted = 1'b0;
		end else begin
			cur_mode   = mode_q;
			cur_which  = which_q;
			cur_index  = index_q;
			cur_hex    = hex_q;
			cur_frac   = frac_q;
			cur_pos    = pos_q;
			cur_tstart = tstart_q;
			cur_halted = halted_q;
		end
	end

	assign next_pos = (cur_pos == PosMax) ? cur_pos : cur_pos + P'(1);
	assign len_pos  = cur_pos - cur_tstart;
	assign len_next = next_pos - cur_tstart;

	assign lw     = (cur_which == 2'd3) ? 2'd0 : cur_which;
	assign llen   = (lw == 2'd2) ? 3'd5 : 3'd4;
	assign li     = (cur_index < llen) ? cur_index : 3'd0;
	assign li_inc = li + 3'd1;

	always_comb begin
		idle_space = is_space(b);
		idle_emit  = 1'b0;
		idle_fail  = 1'b0;
		idle_lit   = 1'b0;
		idle_mode  = jts_pkg::M_IDLE;
		idle_kind  = jts_pkg::K_NULL;
		idle_which = 2'd0;
		unique case (b)
			"n": begin idle_lit = 1'b1; idle_which = 2'd0; idle_mode = jts_pkg::M_LIT; end
			"t": begin idle_lit = 1'b1; idle_which = 2'd1; idle_mode = jts_pkg::M_LIT; end
			"f": begin idle_lit = 1'b1; idle_which = 2'd2; idle_mode = jts_pkg::M_LIT; end
			"\"": idle_mode = jts_pkg::M_STR;
			"-": idle_mode = jts_pkg::M_NSIGN;
			"0": idle_mode = jts_pkg::M_NZERO;
			"[": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_ARR_S; end
			"]": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_ARR_E; end
			"{": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_OBJ_S; end
			"}": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_OBJ_E; end
			":": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_COLON; end
			",": begin idle_emit = 1'b1; idle_kind = jts_pkg::K_COMMA; end
			default: begin
				if (is_digit(b))
					idle_mode = jts_pkg::M_NINT;
				else if (!idle_space)
					idle_fail = 1'b1;
			end
		endcase
	end

	always_comb begin
		raw_ev_t num_ev, fail_ev, iev;
		num_ev  = mk_ev(cur_frac ? jts_pkg::K_DOUBLE : jts_pkg::K_INT, cur_tstart, len_pos,
			jts_pkg::E_NONE);
		fail_ev = mk_ev(jts_pkg::K_UNKNOWN, cur_tstart, len_pos, jts_pkg::E_NONE);
		iev     = mk_ev(jts_pkg::K_NULL, cur_pos, '0, jts_pkg::E_NONE);

		n_mode   = cur_mode;
		n_which  = cur_which;
		n_index  = cur_index;
		n_hex    = cur_hex;
		n_frac   = cur_frac;
		n_tstart = cur_tstart;
		n_halted = cur_halted;
		r0       = mk_ev(jts_pkg::K_NULL, '0, '0, jts_pkg::E_NONE);
		r1       = r0;
		cnt      = 2'd0;
		use_idle = 1'b0;

		if (!cur_halted && item.is_end) begin
			unique case (cur_mode)
				jts_pkg::M_LIT:  begin fail_ev.err = jts_pkg::E_INCOMPLETE_LIT; r0 = fail_ev; cnt = 2'd1; end
				jts_pkg::M_STR:  begin fail_ev.err = jts_pkg::E_UNTERM_STR; r0 = fail_ev; cnt = 2'd1; end
				jts_pkg::M_ESC, jts_pkg::M_HEX: begin
					fail_ev.err = jts_pkg::E_BAD_ESCAPE; r0 = fail_ev; cnt = 2'd1;
				end
				jts_pkg::M_NSIGN, jts_pkg::M_NZBAD: begin
					fail_ev.err = jts_pkg::E_BAD_INT; r0 = fail_ev; cnt = 2'd1;
				end
				jts_pkg::M_FDOT: begin fail_ev.err = jts_pkg::E_BAD_FRAC; r0 = fail_ev; cnt = 2'd1; end
				jts_pkg::M_EXPE, jts_pkg::M_EXPS: begin
					fail_ev.err = jts_pkg::E_BAD_EXP; r0 = fail_ev; cnt = 2'd1;
				end
				jts_pkg::M_NZERO, jts_pkg::M_NINT, jts_pkg::M_FRAC, jts_pkg::M_EXP: begin
					r0  = num_ev;
					r1  = mk_ev(jts_pkg::K_END, cur_pos, '0, jts_pkg::E_NONE);
					cnt = 2'd2;
				end
				default: begin
					r0  = mk_ev(jts_pkg::K_END, cur_pos, '0, jts_pkg::E_NONE);
					cnt = 2'd1;
				end
			endcase
			if (cnt == 2'd1 && r0.kind == jts_pkg::K_UNKNOWN)
				n_halted = 1'b1;
			n_mode = jts_pkg::M_IDLE;
		end else if (!cur_halted) begin
			unique case (cur_mode)
				jts_pkg::M_LIT: begin
					if (lit_char(lw, li) != b) begin
						fail_ev.err = jts_pkg::E_WRONG_LIT;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end else begin
						n_index = li_inc;
						if (li_inc >= llen) begin
							n_mode = jts_pkg::M_IDLE;
							r0 = mk_ev((lw == 2'd0) ? jts_pkg::K_NULL : jts_pkg::K_BOOL,
								cur_tstart, len_next, jts_pkg::E_NONE);
							cnt = 2'd1;
						end
					end
				end
				jts_pkg::M_STR: begin
					if (b == "\"") begin
						n_mode = jts_pkg::M_IDLE;
						r0 = mk_ev(jts_pkg::K_STRING, cur_tstart, len_next, jts_pkg::E_NONE);
						cnt = 2'd1;
					end else if (b == "\\") begin
						n_mode = jts_pkg::M_ESC;
					end
				end
				jts_pkg::M_ESC: begin
					if (b == "u") begin
						n_hex  = 3'd0;
						n_mode = jts_pkg::M_HEX;
					end else if (b == "\"" || b == "\\" || b == "/" || b == "b" ||
							b == "f" || b == "n" || b == "r" || b == "t") begin
						n_mode = jts_pkg::M_STR;
					end else begin
						// the bad escape byte itself is counted
						r0 = mk_ev(jts_pkg::K_UNKNOWN, cur_tstart, len_next,
							jts_pkg::E_BAD_ESCAPE);
						cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end
				end
				jts_pkg::M_HEX: begin
					if (!is_hex(b)) begin
						fail_ev.err = jts_pkg::E_BAD_ESCAPE;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end else begin
						n_hex = cur_hex + 3'd1;
						if (cur_hex + 3'd1 >= 3'd4)
							n_mode = jts_pkg::M_STR;
					end
				end
				jts_pkg::M_NSIGN: begin
					if (b == "0")
						n_mode = jts_pkg::M_NZERO;
					else if (is_digit(b))
						n_mode = jts_pkg::M_NINT;
					else begin
						fail_ev.err = jts_pkg::E_BAD_INT;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end
				end
				jts_pkg::M_NZERO, jts_pkg::M_NINT: begin
					if (is_digit(b)) begin
						if (cur_mode == jts_pkg::M_NZERO)
							n_mode = jts_pkg::M_NZBAD;
					end else if (b == ".") begin
						n_mode = jts_pkg::M_FDOT;
					end else if (b == "e" || b == "E") begin
						n_mode = jts_pkg::M_EXPE;
					end else begin
						r0 = num_ev; cnt = 2'd1; n_mode = jts_pkg::M_IDLE; use_idle = 1'b1;
					end
				end
				jts_pkg::M_NZBAD: begin
					if (!is_digit(b)) begin
						fail_ev.err = jts_pkg::E_BAD_INT;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end
				end
				jts_pkg::M_FDOT: begin
					if (!is_digit(b)) begin
						fail_ev.err = jts_pkg::E_BAD_FRAC;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end else begin
						n_frac = 1'b1;
						n_mode = jts_pkg::M_FRAC;
					end
				end
				jts_pkg::M_FRAC, jts_pkg::M_EXP: begin
					if (is_digit(b)) begin
						n_mode = cur_mode;
					end else if (cur_mode == jts_pkg::M_FRAC && (b == "e" || b == "E")) begin
						n_mode = jts_pkg::M_EXPE;
					end else begin
						r0 = num_ev; cnt = 2'd1; n_mode = jts_pkg::M_IDLE; use_idle = 1'b1;
					end
				end
				jts_pkg::M_EXPE: begin
					if (b == "+" || b == "-")
						n_mode = jts_pkg::M_EXPS;
					else if (is_digit(b))
						n_mode = jts_pkg::M_EXP;
					else begin
						fail_ev.err = jts_pkg::E_BAD_EXP;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end
				end
				jts_pkg::M_EXPS: begin
					if (is_digit(b))
						n_mode = jts_pkg::M_EXP;
					else begin
						fail_ev.err = jts_pkg::E_BAD_EXP;
						r0 = fail_ev; cnt = 2'd1; n_halted = 1'b1; n_mode = jts_pkg::M_IDLE;
					end
				end
				default: begin
					n_mode   = jts_pkg::M_IDLE;
					use_idle = 1'b1;
				end
			endcase

			// byte scanned from idle, possibly right after a number closed
			if (use_idle && !idle_space) begin
				n_tstart = cur_pos;
				n_frac   = 1'b0;
				n_mode   = idle_mode;
				if (idle_lit) begin
					n_which = idle_which;
					n_index = 3'd1;
				end
				if (idle_emit || idle_fail) begin
					iev.kind = idle_fail ? jts_pkg::K_UNKNOWN : idle_kind;
					iev.len  = P'(1);
					iev.err  = idle_fail ? jts_pkg::E_UNKNOWN_BYTE : jts_pkg::E_NONE;
					if (idle_fail)
						n_halted = 1'b1;
					if (cnt == 2'd0) begin
						r0  = iev;
						cnt = 2'd1;
					end else begin
						r1  = iev;
						cnt = 2'd2;
					end
				end
			end
		end

		n_pos = (!cur_halted && !item.is_end && !n_halted) ? next_pos : cur_pos;
	end

	always_comb begin
		ev0.kind  = r0.kind;
		ev0.start = clamp_out(r0.start);
		ev0.len   = clamp_out(r0.len);
		ev0.err   = r0.err;
		ev0.last  = (cnt == 2'd1);
		ev1.kind  = r1.kind;
		ev1.start = clamp_out(r1.start);
		ev1.len   = clamp_out(r1.len);
		ev1.err   = r1.err;
		ev1.last  = 1'b1;
		ev_cnt    = go ? cnt : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= jts_pkg::M_IDLE;
			which_q  <= '0;
			index_q  <= '0;
			hex_q    <= '0;
			frac_q   <= 1'b0;
			pos_q    <= '0;
			tstart_q <= '0;
			halted_q <= 1'b0;
		end else if (go) begin
			mode_q   <= n_mode;
			which_q  <= n_which;
			index_q  <= n_index;
			hex_q    <= n_hex;
			frac_q   <= n_frac;
			pos_q    <= n_pos;
			tstart_q <= n_tstart;
			halted_q <= n_halted;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/jts_event_fifo.sv -----
// Small event queue: takes up to two events a cycle, hands out one.
`default_nettype none
module jts_event_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [1:0]      push_cnt,
	input  wire jts_pkg::event_t ev0,
	input  wire jts_pkg::event_t ev1,
	input  wire logic            pop,
	output jts_pkg::event_t      head,
	output logic                 not_empty,
	output logic                 room2
);

	localparam int AW = $clog2(jts_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(jts_pkg::FIFO_DEPTH + 1);

	jts_pkg::event_t mem_q [jts_pkg::FIFO_DEPTH];
	logic [AW-1:0]   wptr_q, rptr_q;
	logic [CW-1:0]   count_q;
	logic            do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= CW'(jts_pkg::FIFO_DEPTH - 2));
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0)
			mem_q[wptr_q] <= ev0;
		if (push_cnt == 2'd2)
			mem_q[wptr_q + AW'(1)] <= ev1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + AW'(push_cnt);
			rptr_q  <= rptr_q + AW'(do_pop);
			count_q <= count_q + CW'(push_cnt) - CW'(do_pop);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/json_token_scanner.sv -----
// Top level of the streaming JSON token scanner.
// Takes one text byte (or an end mark) per beat and emits one event per token: kind,
// start offset, raw length and error code, with last_of_run on the final event of a beat.
// An input beat is registered, scanned and its events written into a four-entry
// queue, so the first event of a beat reaches the event port through the input
// register and the queue write, and is held there until the event side takes it.
// The scanner takes one beat per cycle as long as each beat yields at most one event
// and the event side takes one event per cycle; a beat that yields two (a number closed
// by a structural character or an unknown byte, or by the end mark) writes both into
// the queue at once, and the queue hands out one event per cycle.
// Offsets count bytes over POSITION_BITS and saturate; reported fields saturate at 2^32-1.
`default_nettype none
module json_token_scanner #(
	parameter int POSITION_BITS = jts_pkg::POSITION_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  in_byte,
	input  wire logic        is_end,
	input  wire logic        doc_start,
	output logic             event_valid,
	input  wire logic        event_ready,
	output logic [3:0]       token_kind,
	output logic [31:0]      start_offset,
	output logic [31:0]      token_length,
	output logic [3:0]       error_code,
	output logic             last_of_run
);

	logic            valid_s1;
	jts_pkg::item_t  item_s1;
	logic            go, room2, take;
	logic [1:0]      ev_cnt;
	jts_pkg::event_t ev0, ev1, head;

	assign go         = valid_s1 && room2;
	assign item_ready = !valid_s1 || go;
	assign take       = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (take)
			valid_s1 <= 1'b1;
		else if (go)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.in_byte   <= in_byte;
			item_s1.is_end    <= is_end;
			item_s1.doc_start <= doc_start;
		end
	end

	jts_scan_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.ev0    (ev0),
		.ev1    (ev1),
		.ev_cnt (ev_cnt)
	);

	jts_event_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_cnt  (ev_cnt),
		.ev0       (ev0),
		.ev1       (ev1),
		.pop       (event_ready),
		.head      (head),
		.not_empty (event_valid),
		.room2     (room2)
	);

	assign token_kind   = head.kind;
	assign start_offset = head.start;
	assign token_length = head.len;
	assign error_code   = head.err;
	assign last_of_run  = head.last;

endmodule
`default_nettype wire

// ----- rtl/core/jts_checker.sv -----
// Port-level checker for the JSON token scanner, bound to the top level.
`default_nettype none
`include "json_token_scanner_defines.svh"
module jts_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        item_valid,
	input wire logic        item_ready,
	input wire logic        event_valid,
	input wire logic        event_ready,
	input wire logic [3:0]  token_kind,
	input wire logic [31:0] start_offset,
	input wire logic [31:0] token_length,
	input wire logic [3:0]  error_code,
	input wire logic        last_of_run
);

	// a stalled event beat stays valid and holds its kind, offset and length
	`JTS_ASSERT_NEXT(a_event_hold, event_valid && !event_ready, event_valid && $stable(token_kind) && $stable(start_offset) && $stable(token_length))
	// only error events carry a code
	`JTS_ASSERT_SAME(a_ok_no_err, event_valid && token_kind != jts_pkg::K_UNKNOWN, error_code == jts_pkg::E_NONE)
	// an error carries a code and always closes its run
	`JTS_ASSERT_SAME(a_err_last, event_valid && token_kind == jts_pkg::K_UNKNOWN, error_code != jts_pkg::E_NONE && last_of_run)
	// end of text is empty and closes its run
	`JTS_ASSERT_SAME(a_end_last, event_valid && token_kind == jts_pkg::K_END, token_length == '0 && last_of_run)

endmodule

bind json_token_scanner jts_checker u_jts_checker (.*);
`default_nettype wire
